### design/min_distance_frontier_queue_unit_assert.svh
// Assertion macros for the frontier queue unit.
`ifndef MIN_DISTANCE_FRONTIER_QUEUE_UNIT_ASSERT_SVH
`define MIN_DISTANCE_FRONTIER_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MDFQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mdfq: assertion failed");
`define MDFQ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("mdfq: reset check failed");
`else
`define MDFQ_ASSERT(label, prop)
`define MDFQ_ASSERT_RST(label, prop)
`endif
`endif

### design/mdfq_pkg.sv
`default_nettype none

package mdfq_pkg;

  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int VERTEX_COUNT_DEF = 256;
  localparam int DIST_WIDTH_DEF   = 31;

  localparam int CAP_W    = 7;
  localparam int VTX_W    = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_SET_DIST = 2'd1,
    CMD_EXTRACT  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### design/mdfq_ram.sv
`default_nettype none

module mdfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/min_distance_frontier_queue_unit.sv
// Frontier queue for a shortest-path search. Vertices are queued in arrival
// order in a slot memory; a second memory holds one distance per vertex.
// Enqueue and set-distance finish in the cycle they are accepted. Extract
// scans every queued slot through the two memories, one slot per cycle
// (slot read, then distance read, then compare; later entry wins ties),
// then closes the gap by moving each later slot up one place through the
// same slot memory port. After reset the distance memory is cleared to
// unreached, one entry per cycle, during which no item is accepted;
// capacity writes are taken at any time. Results wait in an output register.
`default_nettype none

`include "min_distance_frontier_queue_unit_assert.svh"

module min_distance_frontier_queue_unit #(
  parameter int QUEUE_DEPTH  = mdfq_pkg::QUEUE_DEPTH_DEF,
  parameter int VERTEX_COUNT = mdfq_pkg::VERTEX_COUNT_DEF,
  parameter int DIST_WIDTH   = mdfq_pkg::DIST_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mdfq_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [mdfq_pkg::CMD_W-1:0]    command_i,
  input  wire logic [mdfq_pkg::VTX_W-1:0]    vertex_i,
  input  wire logic [DIST_WIDTH-1:0]         distance_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [mdfq_pkg::STATUS_W-1:0] status_o,
  output logic      [mdfq_pkg::VTX_W-1:0]    min_vertex_o,
  output logic      [DIST_WIDTH-1:0]         min_distance_o,
  output logic      [mdfq_pkg::OCC_W-1:0]    occupancy_o
);

  localparam int SlotAw = $clog2(QUEUE_DEPTH);
  localparam int DistAw = $clog2(VERTEX_COUNT);
  localparam logic [DIST_WIDTH-1:0] DistMax = {DIST_WIDTH{1'b1}};
  localparam logic [DistAw-1:0] ClrLast = DistAw'(VERTEX_COUNT - 1);

  mdfq_pkg::state_e  state_q, state_d;
  mdfq_pkg::cmd_e    cmd;
  mdfq_pkg::status_e status_q, status_d;

  logic [mdfq_pkg::CAP_W-1:0] cap_q;
  logic [mdfq_pkg::OCC_W-1:0] count_q, count_d;
  logic [mdfq_pkg::OCC_W-1:0] issue_q, issue_d;
  logic [mdfq_pkg::OCC_W-1:0] s1_idx_q, s1_idx_d;
  logic [mdfq_pkg::OCC_W-1:0] s2_idx_q, s2_idx_d;
  logic [mdfq_pkg::OCC_W-1:0] pos_q, pos_d, pos_new;
  logic [DistAw-1:0]          clr_q, clr_d;
  logic                       s1_v_q, s1_v_d;
  logic                       s2_v_q, s2_v_d;
  logic                       s2_inr_q, s2_inr_d;
  logic [mdfq_pkg::VTX_W-1:0] s2_vtx_q, s2_vtx_d;
  logic [mdfq_pkg::VTX_W-1:0] bvtx_q, bvtx_d;
  logic [DIST_WIDTH-1:0]      best_q, best_d;

  logic                       out_valid_q, out_valid_d;
  logic [mdfq_pkg::VTX_W-1:0] mv_q, mv_d;
  logic [DIST_WIDTH-1:0]      md_q, md_d;
  logic [mdfq_pkg::OCC_W-1:0] occ_q, occ_d;

  logic                  out_free, in_fire, enq_ok, enq_go, issue_en;
  logic                  cand_upd, last_cmp;
  logic [DIST_WIDTH-1:0] cand_dist;

  logic                       slot_we;
  logic [SlotAw-1:0]          slot_waddr, slot_raddr;
  logic [mdfq_pkg::VTX_W-1:0] slot_wdata, slot_rdata;
  logic                       dist_we;
  logic [DistAw-1:0]          dist_waddr, dist_raddr;
  logic [DIST_WIDTH-1:0]      dist_wdata, dist_rdata;

  mdfq_ram #(
    .WIDTH(mdfq_pkg::VTX_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(slot_wdata),
    .raddr_i(slot_raddr),
    .rdata_o(slot_rdata)
  );

  mdfq_ram #(
    .WIDTH(DIST_WIDTH),
    .DEPTH(VERTEX_COUNT)
  ) u_dist_ram (
    .clk_i  (clk_i),
    .we_i   (dist_we),
    .waddr_i(dist_waddr),
    .wdata_i(dist_wdata),
    .raddr_i(dist_raddr),
    .rdata_o(dist_rdata)
  );

  assign cmd       = mdfq_pkg::cmd_e'(command_i);
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == mdfq_pkg::S_IDLE) && out_free;
  assign in_fire   = in_valid_i && in_ready_o;
  assign enq_ok    = (count_q < cap_q) && (int'(count_q) < QUEUE_DEPTH);
  assign enq_go    = (cmd == mdfq_pkg::CMD_ENQUEUE) && enq_ok;
  assign issue_en  = issue_q < count_q;
  assign cand_dist = s2_inr_q ? dist_rdata : DistMax;
  assign cand_upd  = s2_v_q && (cand_dist <= best_q);
  assign last_cmp  = (state_q == mdfq_pkg::S_SCAN) && s2_v_q &&
                     (s2_idx_q == count_q - 7'd1);
  assign pos_new   = cand_upd ? s2_idx_q : pos_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdfq_pkg::S_CLEAR: begin
        if (clr_q == ClrLast) begin
          state_d = mdfq_pkg::S_IDLE;
        end
      end
      mdfq_pkg::S_IDLE: begin
        if (in_fire && cmd == mdfq_pkg::CMD_EXTRACT && count_q != '0) begin
          state_d = mdfq_pkg::S_SCAN;
        end
      end
      mdfq_pkg::S_SCAN: begin
        if (last_cmp) begin
          state_d = mdfq_pkg::S_SHIFT;
        end
      end
      mdfq_pkg::S_SHIFT: begin
        if (!issue_en && !s1_v_q) begin
          state_d = mdfq_pkg::S_DONE;
        end
      end
      mdfq_pkg::S_DONE: begin
        if (out_free) begin
          state_d = mdfq_pkg::S_IDLE;
        end
      end
      default: state_d = mdfq_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_d     = count_q;
    issue_d     = issue_q;
    clr_d       = clr_q;
    s1_v_d      = 1'b0;
    s1_idx_d    = issue_q;
    s2_v_d      = 1'b0;
    s2_idx_d    = s1_idx_q;
    s2_vtx_d    = slot_rdata;
    s2_inr_d    = int'(slot_rdata) < VERTEX_COUNT;
    best_d      = best_q;
    pos_d       = pos_q;
    bvtx_d      = bvtx_q;
    slot_we     = 1'b0;
    slot_waddr  = SlotAw'(count_q);
    slot_wdata  = vertex_i;
    slot_raddr  = SlotAw'(issue_q);
    dist_we     = 1'b0;
    dist_waddr  = DistAw'(vertex_i);
    dist_wdata  = distance_i;
    dist_raddr  = DistAw'(slot_rdata);
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    mv_d        = mv_q;
    md_d        = md_q;
    occ_d       = occ_q;

    unique case (state_q)
      mdfq_pkg::S_CLEAR: begin
        dist_we    = 1'b1;
        dist_waddr = clr_q;
        dist_wdata = DistMax;
        clr_d      = clr_q + DistAw'(1);
      end
      mdfq_pkg::S_IDLE: begin
        if (in_fire) begin
          out_valid_d = 1'b1;
          status_d    = mdfq_pkg::STATUS_DONE;
          mv_d        = '0;
          md_d        = '0;
          occ_d       = count_q;
          unique case (cmd)
            mdfq_pkg::CMD_ENQUEUE: begin
              if (enq_ok) begin
                slot_we = 1'b1;
                count_d = count_q + 7'd1;
                occ_d   = count_q + 7'd1;
              end else begin
                status_d = mdfq_pkg::STATUS_FULL;
              end
            end
            mdfq_pkg::CMD_SET_DIST: begin
              dist_we = int'(vertex_i) < VERTEX_COUNT;
            end
            mdfq_pkg::CMD_EXTRACT: begin
              if (count_q == '0) begin
                status_d = mdfq_pkg::STATUS_EMPTY;
              end else begin
                out_valid_d = out_valid_q && !out_ready_i;
                issue_d     = '0;
                best_d      = DistMax;
                pos_d       = '0;
              end
            end
            default: ;
          endcase
        end
      end
      mdfq_pkg::S_SCAN: begin
        if (issue_en) begin
          issue_d = issue_q + 7'd1;
          s1_v_d  = 1'b1;
        end
        s2_v_d = s1_v_q;
        if (cand_upd) begin
          best_d = cand_dist;
          pos_d  = s2_idx_q;
          bvtx_d = s2_vtx_q;
        end
        if (last_cmp) begin
          issue_d = pos_new + 7'd1;
        end
      end
      mdfq_pkg::S_SHIFT: begin
        if (issue_en) begin
          issue_d = issue_q + 7'd1;
          s1_v_d  = 1'b1;
        end
        if (s1_v_q) begin
          slot_we    = 1'b1;
          slot_waddr = SlotAw'(s1_idx_q - 7'd1);
          slot_wdata = slot_rdata;
        end
      end
      mdfq_pkg::S_DONE: begin
        if (out_free) begin
          count_d     = count_q - 7'd1;
          out_valid_d = 1'b1;
          status_d    = mdfq_pkg::STATUS_DONE;
          mv_d        = bvtx_q;
          md_d        = best_q;
          occ_d       = count_q - 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdfq_pkg::S_CLEAR;
      cap_q       <= mdfq_pkg::CAP_RESET;
      count_q     <= '0;
      issue_q     <= '0;
      clr_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      clr_q       <= clr_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= s1_idx_d;
    s2_idx_q <= s2_idx_d;
    s2_vtx_q <= s2_vtx_d;
    s2_inr_q <= s2_inr_d;
    best_q   <= best_d;
    pos_q    <= pos_d;
    bvtx_q   <= bvtx_d;
    status_q <= status_d;
    mv_q     <= mv_d;
    md_q     <= md_d;
    occ_q    <= occ_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign min_vertex_o   = mv_q;
  assign min_distance_o = md_q;
  assign occupancy_o    = occ_q;

  `MDFQ_ASSERT(a_scan_keeps_count, (state_q == mdfq_pkg::S_SCAN) |=> (count_q == $past(count_q)))
  `MDFQ_ASSERT(a_extract_pops_one, (state_q == mdfq_pkg::S_DONE && out_free) |=> (count_q == $past(count_q) - 7'd1))
  `MDFQ_ASSERT(a_enqueue_pushes_one, (in_fire && enq_go) |=> (count_q == $past(count_q) + 7'd1))
  `MDFQ_ASSERT_RST(a_no_accept_in_reset, !rst_ni |=> !in_ready_o)

endmodule

`default_nettype wire

### test/tb_min_distance_frontier_queue_unit.sv
`timescale 1ns / 1ps

module tb_min_distance_frontier_queue_unit;

  localparam int DW          = mdfq_pkg::DIST_WIDTH_DEF;
  localparam int DEPTH       = mdfq_pkg::QUEUE_DEPTH_DEF;
  localparam int NUM_VTX     = mdfq_pkg::VERTEX_COUNT_DEF;
  localparam int CMD_W       = mdfq_pkg::CMD_W;
  localparam int VTX_W       = mdfq_pkg::VTX_W;
  localparam int STATUS_W    = mdfq_pkg::STATUS_W;
  localparam int OCC_W       = mdfq_pkg::OCC_W;
  localparam int CAP_W       = mdfq_pkg::CAP_W;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 2 * DEPTH + 24;
  localparam int STALL_LIMIT = 4000;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam logic [DW-1:0]    UNREACHED = '1;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] vtx;
    logic [DW-1:0]    distance;
  } frontier_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VTX_W-1:0]    vtx;
    logic [DW-1:0]       distance;
    logic [OCC_W-1:0]    occ;
  } frontier_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [CMD_W-1:0]    command_i = '0;
  logic [VTX_W-1:0]    vertex_i = '0;
  logic [DW-1:0]       distance_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [VTX_W-1:0]    min_vertex_o;
  logic [DW-1:0]       min_distance_o;
  logic [OCC_W-1:0]    occupancy_o;

  min_distance_frontier_queue_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .vertex_i       (vertex_i),
    .distance_i     (distance_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .min_vertex_o   (min_vertex_o),
    .min_distance_o (min_distance_o),
    .occupancy_o    (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [VTX_W-1:0] frontier_slots[$];
  logic [DW-1:0]    dist_table[NUM_VTX];
  logic [CAP_W-1:0] cap_limit = mdfq_pkg::CAP_RESET;

  frontier_cmd_t    cmd_backlog[$];
  frontier_result_t expected_results[$];
  int               results_owed = 0;
  int               err_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int               hold_off_cycles = 0;
  logic             in_took = 1'b0;

  logic [CAP_W-1:0] phase_cap[NUM_PHASES] =
    '{7'd3, 7'd127, 7'd0, 7'd64, 7'd1, 7'd40, 7'd64, 7'd127};
  int               phase_enq_w[NUM_PHASES] = '{45, 50, 30, 35, 40, 45, 30, 40};

  initial begin
    for (int v = 0; v < NUM_VTX; v++) dist_table[v] = UNREACHED;
  end

  function automatic frontier_result_t frontier_predict(frontier_cmd_t c);
    frontier_result_t res;
    logic [DW-1:0]    best;
    int               pos;
    int               lim;
    res = '0;
    res.status = mdfq_pkg::STATUS_DONE;
    lim = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
    case (c.cmd)
      mdfq_pkg::CMD_ENQUEUE: begin
        if (frontier_slots.size() < lim) frontier_slots.push_back(c.vtx);
        else res.status = mdfq_pkg::STATUS_FULL;
      end
      mdfq_pkg::CMD_SET_DIST: begin
        dist_table[c.vtx] = c.distance;
      end
      mdfq_pkg::CMD_EXTRACT: begin
        if (frontier_slots.size() == 0) begin
          res.status = mdfq_pkg::STATUS_EMPTY;
        end else begin
          best = UNREACHED;
          pos = 0;
          for (int i = 0; i < frontier_slots.size(); i++) begin
            if (dist_table[frontier_slots[i]] <= best) begin
              best = dist_table[frontier_slots[i]];
              pos = i;
            end
          end
          res.vtx = frontier_slots[pos];
          res.distance = best;
          frontier_slots.delete(pos);
        end
      end
      default: ;
    endcase
    res.occ = OCC_W'(frontier_slots.size());
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic queue_item(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] vtx,
                            logic [DW-1:0] dist_val);
    frontier_cmd_t c;
    c.cmd = cmd;
    c.vtx = vtx;
    c.distance = dist_val;
    cmd_backlog.push_back(c);
    results_owed++;
  endtask

  task automatic drain_results();
    while (results_owed > 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    cap_limit = cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // hot vertex pool and small distances give ties and repeat hits
  task automatic queue_random_item(int enq_w);
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] vtx;
    logic [DW-1:0]    dist_val;
    int               r;
    r = int'($urandom_range(99));
    if (r < enq_w) cmd = mdfq_pkg::CMD_ENQUEUE;
    else if (r < enq_w + 30) cmd = mdfq_pkg::CMD_SET_DIST;
    else if (r < 97) cmd = mdfq_pkg::CMD_EXTRACT;
    else cmd = CMD_NOP;
    vtx = ($urandom_range(99) < 70) ? VTX_W'($urandom_range(15))
                                    : VTX_W'($urandom_range(NUM_VTX - 1));
    r = int'($urandom_range(9));
    if (r == 0) dist_val = '0;
    else if (r == 1) dist_val = UNREACHED;
    else if (r < 6) dist_val = DW'($urandom_range(15));
    else dist_val = DW'($urandom());
    queue_item(cmd, vtx, dist_val);
  endtask

  always @(negedge clk_i) begin : item_driver
    frontier_cmd_t nxt;
    if (!in_valid_i || in_took) begin
      if (rst_ni && cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        in_valid_i <= 1'b1;
        command_i  <= nxt.cmd;
        vertex_i   <= nxt.vtx;
        distance_i <= nxt.distance;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_took = 1'b0;
  end

  always @(negedge clk_i) begin : result_sink
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : frontier_monitor
    frontier_result_t want;
    frontier_cmd_t    got_cmd;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_owed--;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(min_vertex_o), 64'(0));
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 64'(status_o), 64'(want.status));
          if (min_vertex_o !== want.vtx)
            report_mismatch("min_vertex", 64'(min_vertex_o), 64'(want.vtx));
          if (min_distance_o !== want.distance)
            report_mismatch("min_distance", 64'(min_distance_o), 64'(want.distance));
          if (occupancy_o !== want.occ)
            report_mismatch("occupancy", 64'(occupancy_o), 64'(want.occ));
        end
      end
      if (in_valid_i && in_ready_o) begin
        got_cmd.cmd      = command_i;
        got_cmd.vtx      = vertex_i;
        got_cmd.distance = distance_i;
        expected_results.push_back(frontier_predict(got_cmd));
        in_took = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    int stall_cycles;
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("min_distance_frontier_queue_unit test failed");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty extract, extreme distances, ties, unreached, unused command
    queue_item(mdfq_pkg::CMD_EXTRACT, 8'd0, '0);
    queue_item(mdfq_pkg::CMD_SET_DIST, 8'd0, '0);
    queue_item(mdfq_pkg::CMD_SET_DIST, 8'd1, UNREACHED);
    queue_item(mdfq_pkg::CMD_SET_DIST, 8'd255, 31'h2AAA_AAAA);
    queue_item(mdfq_pkg::CMD_SET_DIST, 8'd254, 31'h5555_5555);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd255, '0);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd1, '0);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd0, UNREACHED);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd254, '0);
    queue_item(mdfq_pkg::CMD_EXTRACT, 8'd255, UNREACHED);
    queue_item(mdfq_pkg::CMD_SET_DIST, 8'd2, 31'd5);
    queue_item(mdfq_pkg::CMD_SET_DIST, 8'd3, 31'd5);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd2, '0);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd3, '0);
    queue_item(mdfq_pkg::CMD_EXTRACT, 8'd0, '0);
    queue_item(mdfq_pkg::CMD_EXTRACT, 8'd0, '0);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd7, '0);
    queue_item(CMD_NOP, 8'hFF, UNREACHED);
    queue_item(mdfq_pkg::CMD_EXTRACT, 8'd0, '0);
    queue_item(mdfq_pkg::CMD_EXTRACT, 8'd0, '0);
    queue_item(mdfq_pkg::CMD_EXTRACT, 8'd0, '0);
    queue_item(mdfq_pkg::CMD_ENQUEUE, 8'd128, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_capacity(phase_cap[p]);
      if (p < 3) begin
        send_idle_pct = 8;
        recv_idle_pct = 59;
      end else if (p < 6) begin
        send_idle_pct = 59;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // backpressure: sink stalls while items keep coming
      if (p == 1) hold_off_cycles = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == PHASE_ITEMS / 2) drain_results();
        queue_random_item(phase_enq_w[p]);
      end
    end

    drain_results();
    repeat (SETTLE) @(negedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 64'(0), 64'(expected_results.size()));
    if (err_count == 0) begin
      $display("min_distance_frontier_queue_unit test passed");
    end else begin
      $display("min_distance_frontier_queue_unit test failed");
    end
    $finish;
  end

endmodule
